/* rtl/sfcd_pkg.sv */
// ----------------------------------------------------------------------------
// sfcd_pkg
// Types, constants and helper functions for the frame channel decoder:
// frame geometry, stick calibration constants and constant reciprocals.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    localparam int FRAME_BYTES_DEF   = 18;
    localparam int CENTER_OFFSET_DEF = 1024;

    localparam int STORE_DEPTH   = 18;
    localparam int PAYLOAD_BYTES = STORE_DEPTH - 1;
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int COUNT_W       = 6;
    localparam int COUNT_MAX     = 63;
    localparam int CH_W          = 11;
    localparam int NUM_CH        = 12;

    localparam int DIFF_W      = 13;
    localparam int MAG_W       = 22;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 33;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int SW_W        = 12;

    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic [MAG_W-1:0]         t_mag;
    typedef logic [RECIP_W-1:0]       t_recip;
    typedef logic [CH_W-1:0]          t_chan;
    typedef logic signed [SW_W-1:0]   t_switch;

    localparam int STICK_GAIN = 1400;
    localparam int THR_GAIN   = 25;

    localparam int FWD_DIV = 1596;
    localparam int LAT_DIV = 1312;
    localparam int THR_DIV = 1533;
    localparam int YAW_DIV = 1600;

    localparam t_recip FWD_RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(FWD_DIV) - 64'd1)
                                            / 64'(FWD_DIV));
    localparam t_recip LAT_RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(LAT_DIV) - 64'd1)
                                            / 64'(LAT_DIV));
    localparam t_recip THR_RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(THR_DIV) - 64'd1)
                                            / 64'(THR_DIV));
    localparam t_recip YAW_RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(YAW_DIV) - 64'd1)
                                            / 64'(YAW_DIV));

    // offset plus trim plus map origin, folded into one bias per stick
    localparam t_diff FWD_BIAS = 13'sd820;
    localparam t_diff LAT_BIAS = -13'sd636;
    localparam t_diff THR_BIAS = 13'sd776;
    localparam t_diff YAW_BIAS = 13'sd824;

    localparam t_diff FWD_BASE = 13'sd700;
    localparam t_diff LAT_BASE = -13'sd700;
    localparam t_diff THR_BASE = 13'sd25;
    localparam t_diff YAW_BASE = -13'sd700;

    localparam t_diff FWD_DZ_LO = -13'sd14;
    localparam t_diff FWD_DZ_HI = 13'sd10;
    localparam t_diff LAT_DZ_LO = -13'sd30;
    localparam t_diff LAT_DZ_HI = 13'sd20;
    localparam t_diff THR_DZ_HI = 13'sd3;
    localparam t_diff YAW_DZ_LO = -13'sd22;
    localparam t_diff YAW_DZ_HI = 13'sd22;

    localparam t_switch SWITCH_REF = 12'sd2000;

    function automatic t_mag scale_abs(input t_diff x, input int gain);
        t_diff ax;
        ax = x[DIFF_W-1] ? -x : x;
        return t_mag'({{(MAG_W-DIFF_W){1'b0}}, ax}) * t_mag'(gain);
    endfunction

    function automatic t_diff recip_div(input t_mag m, input t_recip recip, input logic neg);
        logic [PROD_W-1:0] prod;
        t_diff             q;
        prod = PROD_W'(m) * PROD_W'(recip);
        q    = t_diff'({{(DIFF_W-QUOT_W){1'b0}}, prod[RECIP_SHIFT +: QUOT_W]});
        return neg ? -q : q;
    endfunction

    function automatic t_diff halve(input t_diff v);
        t_diff s;
        s = v + {{(DIFF_W-1){1'b0}}, v[DIFF_W-1]};
        return {s[DIFF_W-1], s[DIFF_W-1:1]};
    endfunction

endpackage

/* rtl/sbus_frame_channel_decoder.sv */
// ----------------------------------------------------------------------------
// sbus_frame_channel_decoder
// Collects received bytes into a frame and, on line idle, decodes twelve
// 11-bit channels into calibrated stick values and switch values.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready with i_action and i_data_byte. A
// data transaction (action 0) stores the byte, if not a burst's first, and
// bumps a saturating count. An idle transaction (action 1) ends the burst:
// FRAME_BYTES bytes launch one decode, other lengths drop; the count clears.
// Output channel: o_out_valid / i_out_ready with the twelve decoded fields.
// The decode runs in two register stages: unpack, offset, bias and gain into
// the first, constant-reciprocal divide, base, halving and dead zone into the
// result register. One input transaction is taken per cycle while
// o_in_ready is high; the rate is set by the two-stage decode pipeline,
// which moves one frame per cycle unless stalled.
// When the receiver stalls, the result register holds, then the first stage
// fills, and only then does o_in_ready drop. Reset clears the count and both
// stages; the frame bytes are not cleared and are rewritten by each burst.
// ----------------------------------------------------------------------------
module sbus_frame_channel_decoder #(
    parameter int FRAME_BYTES   = sfcd_pkg::FRAME_BYTES_DEF,
    parameter int CENTER_OFFSET = sfcd_pkg::CENTER_OFFSET_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [7:0]         i_data_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [9:0]  o_stick_fwd,
    output logic signed [10:0] o_stick_lat,
    output logic signed [5:0]  o_stick_thr,
    output logic signed [9:0]  o_stick_yaw,
    output logic [10:0]        o_switch_a,
    output logic [10:0]        o_switch_b,
    output logic signed [11:0] o_switch_c,
    output logic signed [11:0] o_switch_d,
    output logic [10:0]        o_switch_e,
    output logic [10:0]        o_switch_f,
    output logic [10:0]        o_switch_g,
    output logic [10:0]        o_switch_h
);

    logic [sfcd_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [sfcd_pkg::PAYLOAD_W-1:0] r_frame, n_frame;

    logic             r_s1_valid, n_s1_valid;
    sfcd_pkg::t_mag   r_m_fwd, r_m_lat, r_m_thr, r_m_yaw;
    sfcd_pkg::t_mag   n_m_fwd, n_m_lat, n_m_thr, n_m_yaw;
    logic             r_neg_fwd, r_neg_lat, r_neg_thr, r_neg_yaw;
    logic             n_neg_fwd, n_neg_lat, n_neg_thr, n_neg_yaw;
    sfcd_pkg::t_chan  r_raw_a, r_raw_b, r_raw_e, r_raw_f, r_raw_g, r_raw_h;
    sfcd_pkg::t_chan  n_raw_a, n_raw_b, n_raw_e, n_raw_f, n_raw_g, n_raw_h;
    sfcd_pkg::t_switch r_inv_c, r_inv_d, n_inv_c, n_inv_d;

    logic                  r_out_valid, n_out_valid;
    logic signed [9:0]     r_stick_fwd, n_stick_fwd;
    logic signed [10:0]    r_stick_lat, n_stick_lat;
    logic signed [5:0]     r_stick_thr, n_stick_thr;
    logic signed [9:0]     r_stick_yaw, n_stick_yaw;
    sfcd_pkg::t_chan       r_switch_a, r_switch_b, r_switch_e, r_switch_f;
    sfcd_pkg::t_chan       r_switch_g, r_switch_h;
    sfcd_pkg::t_switch     r_switch_c, r_switch_d;

    logic in_accept;
    logic s1_ready;
    logic s2_ready;
    logic launch;
    logic [sfcd_pkg::IDX_W-1:0] wr_idx;
    sfcd_pkg::t_chan ch [sfcd_pkg::NUM_CH];
    sfcd_pkg::t_diff d_fwd, d_lat, d_thr, d_yaw;
    sfcd_pkg::t_diff x_fwd, x_lat, x_thr, x_yaw;
    sfcd_pkg::t_diff v_fwd, v_lat, v_thr, v_yaw;
    sfcd_pkg::t_diff h_fwd, h_lat, h_yaw;

    assign s2_ready   = !r_out_valid || i_out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_ready = s1_ready;
    assign in_accept  = i_in_valid && s1_ready;
    assign launch     = in_accept && i_action
                        && (r_count == sfcd_pkg::COUNT_W'(FRAME_BYTES));
    assign wr_idx     = sfcd_pkg::IDX_W'(r_count - sfcd_pkg::COUNT_W'(1));

    always_comb begin
        n_count = r_count;
        n_frame = r_frame;
        if (in_accept) begin
            if (i_action) begin
                n_count = '0;
            end else begin
                if (r_count != '0 && r_count < sfcd_pkg::COUNT_W'(sfcd_pkg::STORE_DEPTH)) begin
                    n_frame[8*wr_idx +: 8] = i_data_byte;
                end
                if (r_count < sfcd_pkg::COUNT_W'(sfcd_pkg::COUNT_MAX)) begin
                    n_count = r_count + sfcd_pkg::COUNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < sfcd_pkg::NUM_CH; k++) begin
            ch[k] = r_frame[sfcd_pkg::CH_W*k +: sfcd_pkg::CH_W];
        end
        d_fwd = sfcd_pkg::t_diff'({2'b00, ch[2]}) - sfcd_pkg::t_diff'(CENTER_OFFSET);
        d_lat = sfcd_pkg::t_diff'({2'b00, ch[0]}) - sfcd_pkg::t_diff'(CENTER_OFFSET);
        d_thr = sfcd_pkg::t_diff'({2'b00, ch[1]}) - sfcd_pkg::t_diff'(CENTER_OFFSET);
        d_yaw = sfcd_pkg::t_diff'({2'b00, ch[3]}) - sfcd_pkg::t_diff'(CENTER_OFFSET);
        x_fwd = d_fwd + sfcd_pkg::FWD_BIAS;
        x_lat = d_lat + sfcd_pkg::LAT_BIAS;
        x_thr = sfcd_pkg::THR_BIAS - d_thr;
        x_yaw = d_yaw + sfcd_pkg::YAW_BIAS;

        n_m_fwd   = sfcd_pkg::scale_abs(x_fwd, sfcd_pkg::STICK_GAIN);
        n_m_lat   = sfcd_pkg::scale_abs(x_lat, sfcd_pkg::STICK_GAIN);
        n_m_thr   = sfcd_pkg::scale_abs(x_thr, sfcd_pkg::THR_GAIN);
        n_m_yaw   = sfcd_pkg::scale_abs(x_yaw, sfcd_pkg::STICK_GAIN);
        n_neg_fwd = x_fwd > sfcd_pkg::t_diff'(0);
        n_neg_lat = x_lat > sfcd_pkg::t_diff'(0);
        n_neg_thr = x_thr > sfcd_pkg::t_diff'(0);
        n_neg_yaw = x_yaw[sfcd_pkg::DIFF_W-1];

        n_raw_a = ch[4];
        n_raw_b = ch[5];
        n_inv_c = sfcd_pkg::SWITCH_REF - sfcd_pkg::t_switch'({1'b0, ch[6]});
        n_inv_d = sfcd_pkg::SWITCH_REF - sfcd_pkg::t_switch'({1'b0, ch[7]});
        n_raw_e = ch[8];
        n_raw_f = ch[9];
        n_raw_g = ch[10];
        n_raw_h = ch[11];

        n_s1_valid = s1_ready ? launch : r_s1_valid;
    end

    always_comb begin
        v_fwd = sfcd_pkg::recip_div(r_m_fwd, sfcd_pkg::FWD_RECIP, r_neg_fwd)
                + sfcd_pkg::FWD_BASE;
        v_lat = sfcd_pkg::recip_div(r_m_lat, sfcd_pkg::LAT_RECIP, r_neg_lat)
                + sfcd_pkg::LAT_BASE;
        v_thr = sfcd_pkg::recip_div(r_m_thr, sfcd_pkg::THR_RECIP, r_neg_thr)
                + sfcd_pkg::THR_BASE;
        v_yaw = sfcd_pkg::recip_div(r_m_yaw, sfcd_pkg::YAW_RECIP, r_neg_yaw)
                + sfcd_pkg::YAW_BASE;
        h_fwd = sfcd_pkg::halve(v_fwd);
        h_lat = sfcd_pkg::halve(v_lat);
        h_yaw = sfcd_pkg::halve(v_yaw);

        n_stick_fwd = h_fwd[9:0];
        if (h_fwd > sfcd_pkg::FWD_DZ_LO && h_fwd < sfcd_pkg::FWD_DZ_HI) begin
            n_stick_fwd = '0;
        end
        n_stick_lat = h_lat[10:0];
        if (h_lat > sfcd_pkg::LAT_DZ_LO && h_lat < sfcd_pkg::LAT_DZ_HI) begin
            n_stick_lat = '0;
        end
        n_stick_thr = v_thr[5:0];
        if (!v_thr[sfcd_pkg::DIFF_W-1] && v_thr <= sfcd_pkg::THR_DZ_HI) begin
            n_stick_thr = '0;
        end
        n_stick_yaw = h_yaw[9:0];
        if (h_yaw > sfcd_pkg::YAW_DZ_LO && h_yaw < sfcd_pkg::YAW_DZ_HI) begin
            n_stick_yaw = '0;
        end

        n_out_valid = s2_ready ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        if (launch) begin
            r_m_fwd   <= n_m_fwd;
            r_m_lat   <= n_m_lat;
            r_m_thr   <= n_m_thr;
            r_m_yaw   <= n_m_yaw;
            r_neg_fwd <= n_neg_fwd;
            r_neg_lat <= n_neg_lat;
            r_neg_thr <= n_neg_thr;
            r_neg_yaw <= n_neg_yaw;
            r_raw_a   <= n_raw_a;
            r_raw_b   <= n_raw_b;
            r_inv_c   <= n_inv_c;
            r_inv_d   <= n_inv_d;
            r_raw_e   <= n_raw_e;
            r_raw_f   <= n_raw_f;
            r_raw_g   <= n_raw_g;
            r_raw_h   <= n_raw_h;
        end
        if (r_s1_valid && s2_ready) begin
            r_stick_fwd <= n_stick_fwd;
            r_stick_lat <= n_stick_lat;
            r_stick_thr <= n_stick_thr;
            r_stick_yaw <= n_stick_yaw;
            r_switch_a  <= r_raw_a;
            r_switch_b  <= r_raw_b;
            r_switch_c  <= r_inv_c;
            r_switch_d  <= r_inv_d;
            r_switch_e  <= r_raw_e;
            r_switch_f  <= r_raw_f;
            r_switch_g  <= r_raw_g;
            r_switch_h  <= r_raw_h;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_stick_fwd = r_stick_fwd;
    assign o_stick_lat = r_stick_lat;
    assign o_stick_thr = r_stick_thr;
    assign o_stick_yaw = r_stick_yaw;
    assign o_switch_a  = r_switch_a;
    assign o_switch_b  = r_switch_b;
    assign o_switch_c  = r_switch_c;
    assign o_switch_d  = r_switch_d;
    assign o_switch_e  = r_switch_e;
    assign o_switch_f  = r_switch_f;
    assign o_switch_g  = r_switch_g;
    assign o_switch_h  = r_switch_h;

    a_idle_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_action |=> r_count == '0)
        else $error("count not cleared after idle transaction");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_action && r_count == sfcd_pkg::COUNT_W'(sfcd_pkg::COUNT_MAX)
        |=> r_count == sfcd_pkg::COUNT_W'(sfcd_pkg::COUNT_MAX))
        else $error("count wrapped past saturation");

    a_launch_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        launch |=> r_s1_valid)
        else $error("decode launch lost");

    a_result_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result without a decoded frame");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && r_out_valid && !i_out_ready)
        else $error("input stalled with room in the pipeline");

endmodule
